/* hdl/qmm_pkg.sv */
package qmm_pkg;

    localparam int PULSE_W = 11;
    localparam int MIX_W   = 14;

    localparam logic [2:0] OP_ARM    = 3'd0;
    localparam logic [2:0] OP_DISARM = 3'd1;
    localparam logic [2:0] OP_RAMP   = 3'd2;
    localparam logic [2:0] OP_ESTOP  = 3'd3;
    localparam logic [2:0] OP_DIRECT = 3'd4;
    localparam logic [2:0] OP_YAW    = 3'd5;
    localparam logic [2:0] OP_MIX    = 3'd6;

    localparam logic [1:0] CFG_THR_MIN    = 2'd0;
    localparam logic [1:0] CFG_THR_ARM    = 2'd1;
    localparam logic [1:0] CFG_THR_NORMAL = 2'd2;
    localparam logic [1:0] CFG_RAMP_STEP  = 2'd3;

    localparam logic [PULSE_W-1:0] PULSE_LOW  = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_HIGH = 11'd2000;
    localparam logic [PULSE_W-1:0] MIX_MARGIN = 11'd50;

    typedef struct packed {
        logic [PULSE_W-1:0] stop_pulse;
        logic [PULSE_W-1:0] idle_pulse;
        logic [PULSE_W-1:0] cruise_pulse;
        logic [7:0]         slew_step;
    } cfg_t;

    typedef struct packed {
        logic                          armed;
        logic                          ramping;
        logic [PULSE_W-1:0]            target;
        logic [PULSE_W-1:0]            current;
        logic [3:0][PULSE_W-1:0]       motor;
    } state_t;

    // clamp to [floor, 2000], then saturate to the esc range
    function automatic logic [PULSE_W-1:0] esc_clamp(input logic signed [MIX_W-1:0] x,
                                                     input logic signed [MIX_W-1:0] fl);
        logic signed [MIX_W-1:0] y;
        logic signed [MIX_W-1:0] lo;
        logic signed [MIX_W-1:0] hi;
        lo = $signed({3'b000, PULSE_LOW});
        hi = $signed({3'b000, PULSE_HIGH});
        y = (x < fl) ? fl : ((x > hi) ? hi : x);
        if (y < lo) begin
            return PULSE_LOW;
        end else if (y > hi) begin
            return PULSE_HIGH;
        end
        return y[PULSE_W-1:0];
    endfunction

endpackage

/* hdl/qmm_mix.sv */
module qmm_mix (
    input  qmm_pkg::cfg_t                  cfg,
    input  qmm_pkg::state_t                st,
    input  logic [2:0]                     operation,
    input  logic [11:0]                    base_pulse,
    input  logic signed [10:0]             yaw_term,
    input  logic signed [10:0]             pitch_term,
    input  logic signed [10:0]             roll_term,
    output qmm_pkg::state_t                st_next,
    output logic                           written
);

    logic signed [qmm_pkg::MIX_W-1:0] b;
    logic signed [qmm_pkg::MIX_W-1:0] y;
    logic signed [qmm_pkg::MIX_W-1:0] p;
    logic signed [qmm_pkg::MIX_W-1:0] r;
    logic signed [qmm_pkg::MIX_W-1:0] floor_arm;
    logic signed [qmm_pkg::MIX_W-1:0] floor_min;
    logic signed [qmm_pkg::MIX_W-1:0] floor_low;
    logic signed [qmm_pkg::MIX_W-1:0] floor_yaw;
    logic signed [qmm_pkg::MIX_W-1:0] cur_s;
    logic signed [qmm_pkg::MIX_W-1:0] stepped;
    logic signed [qmm_pkg::MIX_W-1:0] stepped_cl;
    logic signed [qmm_pkg::MIX_W-1:0] high_s;
    logic [10:0]                      gap;
    logic                             far;
    logic [10:0]                      cur_new;
    logic [10:0]                      p_ramp;

    assign b         = $signed({2'b00, base_pulse});
    assign y         = {{3{yaw_term[10]}}, yaw_term};
    assign p         = {{3{pitch_term[10]}}, pitch_term};
    assign r         = {{3{roll_term[10]}}, roll_term};
    assign floor_arm = $signed({3'b000, cfg.idle_pulse})
                     + $signed({3'b000, qmm_pkg::MIX_MARGIN});
    assign floor_min = $signed({3'b000, cfg.stop_pulse});
    assign floor_low = $signed({3'b000, qmm_pkg::PULSE_LOW});
    assign high_s    = $signed({3'b000, qmm_pkg::PULSE_HIGH});
    assign floor_yaw = st.armed ? floor_arm : floor_min;

    // ramp step toward target
    assign gap     = (st.current > st.target) ? (st.current - st.target)
                                              : (st.target - st.current);
    assign far     = gap > {3'b000, cfg.slew_step};
    assign cur_s   = $signed({3'b000, st.current});
    assign stepped = (st.current < st.target) ? cur_s + $signed({6'd0, cfg.slew_step})
                                              : cur_s - $signed({6'd0, cfg.slew_step});
    assign stepped_cl = (stepped < floor_min) ? floor_min
                                              : ((stepped > high_s) ? high_s : stepped);
    assign cur_new = far ? stepped_cl[10:0] : st.target;
    assign p_ramp  = qmm_pkg::esc_clamp($signed({3'b000, cur_new}), floor_low);

    always_comb begin
        st_next = st;
        written = 1'b0;
        case (operation)
            qmm_pkg::OP_ARM: begin
                if (!st.armed) begin
                    st_next.armed   = 1'b1;
                    st_next.ramping = 1'b1;
                    st_next.target  = cfg.cruise_pulse;
                    st_next.current = cfg.stop_pulse;
                end
            end
            qmm_pkg::OP_DISARM: begin
                if (st.armed) begin
                    st_next.armed   = 1'b0;
                    st_next.ramping = 1'b0;
                    st_next.target  = cfg.stop_pulse;
                    st_next.current = cfg.stop_pulse;
                end
            end
            qmm_pkg::OP_RAMP: begin
                if (st.ramping) begin
                    st_next.current = cur_new;
                    st_next.ramping = far;
                    st_next.motor   = {4{p_ramp}};
                    written         = 1'b1;
                end
            end
            qmm_pkg::OP_ESTOP: begin
                st_next.armed   = 1'b0;
                st_next.ramping = 1'b0;
                st_next.target  = cfg.stop_pulse;
                st_next.current = cfg.stop_pulse;
                st_next.motor   = {4{qmm_pkg::esc_clamp(floor_min, floor_low)}};
                written         = 1'b1;
            end
            qmm_pkg::OP_DIRECT: begin
                st_next.motor = {4{qmm_pkg::esc_clamp(b, floor_low)}};
                written       = 1'b1;
            end
            qmm_pkg::OP_YAW: begin
                st_next.motor[0] = qmm_pkg::esc_clamp(b + y, floor_yaw);
                st_next.motor[1] = qmm_pkg::esc_clamp(b - y, floor_yaw);
                st_next.motor[2] = qmm_pkg::esc_clamp(b - y, floor_yaw);
                st_next.motor[3] = qmm_pkg::esc_clamp(b + y, floor_yaw);
                written          = 1'b1;
            end
            qmm_pkg::OP_MIX: begin
                if (st.armed) begin
                    st_next.motor[0] = qmm_pkg::esc_clamp(b + y + p + r, floor_arm);
                    st_next.motor[1] = qmm_pkg::esc_clamp(b - y + p - r, floor_arm);
                    st_next.motor[2] = qmm_pkg::esc_clamp(b - y - p - r, floor_arm);
                    st_next.motor[3] = qmm_pkg::esc_clamp(b + y - p + r, floor_arm);
                    written          = 1'b1;
                end
            end
            default: begin
                st_next = st;
            end
        endcase
    end

endmodule

/* hdl/quad_motor_mix_arm_ramp_top.sv */
// path: input beat to result beat through the input register, then the result register
// throughput: one beat per cycle, limited only by m_tready backpressure
// the command decode and mixer sit in one combinational stage between the two registers
// reset: aresetn is synchronous, active low; clears valids, flags, throttles to 1000,
// motors to 1000 and the configuration registers to their defaults
module quad_motor_mix_arm_ramp_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // base_pulse, yaw_term, pitch_term, roll_term, zero pad
    input  logic [2:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // motor_front_left, motor_front_right, motor_rear_right,
                                   // motor_rear_left, is_armed, is_ramping, zero pad
    output logic        m_tuser,   // motors_written
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    qmm_pkg::cfg_t   cfg_reg;
    qmm_pkg::state_t st_reg;
    qmm_pkg::state_t st_next;
    logic            in_valid_reg;
    logic [2:0]      op_reg;
    logic [11:0]     base_reg;
    logic [10:0]     yaw_reg;
    logic [10:0]     pitch_reg;
    logic [10:0]     roll_reg;
    logic            m_valid_reg;
    logic            written_reg;
    logic            written_next;
    logic            advance;

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stop_pulse   <= 11'd1000;
            cfg_reg.idle_pulse   <= 11'd1050;
            cfg_reg.cruise_pulse <= 11'd1200;
            cfg_reg.slew_step    <= 8'd2;
        end else if (cfg_valid) begin
            case (cfg_index)
                qmm_pkg::CFG_THR_MIN:    cfg_reg.stop_pulse   <= cfg_data;
                qmm_pkg::CFG_THR_ARM:    cfg_reg.idle_pulse   <= cfg_data;
                qmm_pkg::CFG_THR_NORMAL: cfg_reg.cruise_pulse <= cfg_data;
                qmm_pkg::CFG_RAMP_STEP:  cfg_reg.slew_step    <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= s_tuser;
            base_reg  <= s_tdata[11:0];
            yaw_reg   <= s_tdata[22:12];
            pitch_reg <= s_tdata[33:23];
            roll_reg  <= s_tdata[44:34];
        end
    end

    qmm_mix u_mix (
        .cfg        (cfg_reg),
        .st         (st_reg),
        .operation  (op_reg),
        .base_pulse (base_reg),
        .yaw_term   (yaw_reg),
        .pitch_term (pitch_reg),
        .roll_term  (roll_reg),
        .st_next    (st_next),
        .written    (written_next)
    );

    // state doubles as the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            st_reg.armed   <= 1'b0;
            st_reg.ramping <= 1'b0;
            st_reg.target  <= qmm_pkg::PULSE_LOW;
            st_reg.current <= qmm_pkg::PULSE_LOW;
            st_reg.motor   <= {4{qmm_pkg::PULSE_LOW}};
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            written_reg <= written_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = written_reg;
    assign m_tdata  = {2'b00, st_reg.ramping, st_reg.armed,
                       st_reg.motor[3], st_reg.motor[2], st_reg.motor[1], st_reg.motor[0]};

endmodule

/* hdl/qmm_check.sv */
module qmm_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:0] >= 11'd1000 && m_tdata[10:0] <= 11'd2000
                  && m_tdata[21:11] >= 11'd1000 && m_tdata[21:11] <= 11'd2000
                  && m_tdata[32:22] >= 11'd1000 && m_tdata[32:22] <= 11'd2000
                  && m_tdata[43:33] >= 11'd1000 && m_tdata[43:33] <= 11'd2000)
        else $error("motor pulse outside esc range");

    a_ramp_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[45] |-> m_tdata[44])
        else $error("ramping while disarmed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind quad_motor_mix_arm_ramp_top qmm_check u_qmm_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* dv/quad_motor_mix_arm_ramp_top_tb.sv */
module quad_motor_mix_arm_ramp_top_tb;

    localparam logic [2:0] OP_NONE = 3'd7;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int NUM_PHASES = 8;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

    class motor_scoreboard;
        int thr_min;
        int thr_arm;
        int thr_normal;
        int step;
        bit armed;
        bit ramping;
        int target;
        int current;
        int motor[4];
        logic [47:0] exp_data[$];
        logic exp_user[$];
        int errors;

        function new();
            thr_min = 1000;
            thr_arm = 1050;
            thr_normal = 1200;
            step = 2;
            armed = 0;
            ramping = 0;
            target = 1000;
            current = 1000;
            foreach (motor[i]) motor[i] = 1000;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] val);
            case (idx)
                qmm_pkg::CFG_THR_MIN:    thr_min = val;
                qmm_pkg::CFG_THR_ARM:    thr_arm = val;
                qmm_pkg::CFG_THR_NORMAL: thr_normal = val;
                qmm_pkg::CFG_RAMP_STEP:  step = val[7:0];
                default: ;
            endcase
        endfunction

        function int bound(int x, int lo, int hi);
            if (x < lo) return lo;
            if (x > hi) return hi;
            return x;
        endfunction

        function int esc(int x, int fl);
            return bound(bound(x, fl, qmm_pkg::PULSE_HIGH), qmm_pkg::PULSE_LOW,
                         qmm_pkg::PULSE_HIGH);
        endfunction

        function void set_all(int v);
            foreach (motor[i]) motor[i] = bound(v, qmm_pkg::PULSE_LOW, qmm_pkg::PULSE_HIGH);
        endfunction

        function void note_command(logic [2:0] op, logic [11:0] base,
                                   logic signed [10:0] yaw, logic signed [10:0] pitch,
                                   logic signed [10:0] roll);
            int b;
            int y;
            int p;
            int r;
            int fl;
            int diff;
            logic wr;
            b = base;
            y = yaw;
            p = pitch;
            r = roll;
            wr = 1'b0;
            case (op)
                qmm_pkg::OP_ARM: begin
                    if (!armed) begin
                        armed = 1;
                        target = thr_normal;
                        current = thr_min;
                        ramping = 1;
                    end
                end
                qmm_pkg::OP_DISARM: begin
                    if (armed) begin
                        armed = 0;
                        target = thr_min;
                        current = thr_min;
                        ramping = 0;
                    end
                end
                qmm_pkg::OP_RAMP: begin
                    if (ramping) begin
                        diff = (current > target) ? current - target : target - current;
                        if (diff > step) begin
                            current = bound(current + ((current < target) ? step : -step),
                                            thr_min, qmm_pkg::PULSE_HIGH) & 'h7ff;
                        end else begin
                            current = target;
                            ramping = 0;
                        end
                        set_all(current);
                        wr = 1'b1;
                    end
                end
                qmm_pkg::OP_ESTOP: begin
                    armed = 0;
                    ramping = 0;
                    target = thr_min;
                    current = thr_min;
                    set_all(thr_min);
                    wr = 1'b1;
                end
                qmm_pkg::OP_DIRECT: begin
                    set_all(b);
                    wr = 1'b1;
                end
                qmm_pkg::OP_YAW: begin
                    fl = armed ? thr_arm + int'(qmm_pkg::MIX_MARGIN) : thr_min;
                    motor[0] = esc(b + y, fl);
                    motor[1] = esc(b - y, fl);
                    motor[2] = esc(b - y, fl);
                    motor[3] = esc(b + y, fl);
                    wr = 1'b1;
                end
                qmm_pkg::OP_MIX: begin
                    if (armed) begin
                        fl = thr_arm + int'(qmm_pkg::MIX_MARGIN);
                        motor[0] = esc(b + y + p + r, fl);
                        motor[1] = esc(b - y + p - r, fl);
                        motor[2] = esc(b - y - p - r, fl);
                        motor[3] = esc(b + y - p + r, fl);
                        wr = 1'b1;
                    end
                end
                default: ;
            endcase
            exp_data.push_back({2'b00, ramping, armed, 11'(motor[3]), 11'(motor[2]),
                                11'(motor[1]), 11'(motor[0])});
            exp_user.push_back(wr);
        endfunction

        function void check_beat(logic [47:0] data, logic user);
            logic [47:0] ed;
            logic eu;
            string names[6];
            int lsb[6];
            int width[6];
            names = '{"motor_front_left", "motor_front_right", "motor_rear_right",
                      "motor_rear_left", "is_armed", "is_ramping"};
            lsb = '{0, 11, 22, 33, 44, 45};
            width = '{11, 11, 11, 11, 1, 1};
            if (exp_data.size() == 0) begin
                $display("%0t unexpected beat: expected none actual data %h user %b",
                         $time, data, user);
                errors++;
                return;
            end
            ed = exp_data.pop_front();
            eu = exp_user.pop_front();
            for (int i = 0; i < 6; i++) begin
                if (((data >> lsb[i]) & ((48'd1 << width[i]) - 1)) !=
                    ((ed >> lsb[i]) & ((48'd1 << width[i]) - 1))) begin
                    $display("%0t %s mismatch: expected %0d actual %0d", $time, names[i],
                             (ed >> lsb[i]) & ((48'd1 << width[i]) - 1),
                             (data >> lsb[i]) & ((48'd1 << width[i]) - 1));
                    errors++;
                end
            end
            if (user !== eu) begin
                $display("%0t motors_written mismatch: expected %b actual %b",
                         $time, eu, user);
                errors++;
            end
        endfunction

        function int pending();
            return exp_data.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    motor_scoreboard sb = new();

    quad_motor_mix_arm_ramp_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(m_tdata, m_tuser);
        end
    end

    task automatic send_command(logic [2:0] op, logic [11:0] base, logic signed [10:0] yaw,
                                logic signed [10:0] pitch, logic signed [10:0] roll);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, roll, pitch, yaw, base};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(op, base, yaw, pitch, roll);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [10:0] tmin, logic [10:0] tarm, logic [10:0] tnorm,
                             logic [10:0] tstep);
        drain();
        write_reg(qmm_pkg::CFG_THR_MIN, tmin);
        write_reg(qmm_pkg::CFG_THR_ARM, tarm);
        write_reg(qmm_pkg::CFG_THR_NORMAL, tnorm);
        write_reg(qmm_pkg::CFG_RAMP_STEP, tstep);
        @(posedge aclk);
    endtask

    function automatic logic [11:0] rand_base();
        if ($urandom_range(1)) return 12'($urandom_range(4095));
        return 12'($urandom_range(2100, 900));
    endfunction

    function automatic logic [10:0] rand_term();
        if ($urandom_range(1)) return 11'($urandom);
        return 11'($urandom_range(400) - 200);
    endfunction

    task automatic send_random(logic [2:0] op);
        send_command(op, rand_base(), rand_term(), rand_term(), rand_term());
    endtask

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int count;
        int k;
        idle_mode_t mode;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_command(qmm_pkg::OP_RAMP, 12'd1500, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_MIX, 12'd1500, 11'sd100, 11'sd100, 11'sd100);
        send_command(qmm_pkg::OP_DISARM, 12'd0, 11'sd0, 11'sd0, 11'sd0);
        send_command(OP_NONE, 12'd4095, -11'sd1024, 11'sd1023, -11'sd1024);
        send_command(qmm_pkg::OP_YAW, 12'd0, -11'sd1024, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_DIRECT, 12'd4095, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_DIRECT, 12'd0, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_ARM, 12'd0, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_ARM, 12'd0, 11'sd0, 11'sd0, 11'sd0);
        repeat (5) send_command(qmm_pkg::OP_RAMP, 12'd0, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_MIX, 12'd4095, 11'sd1023, 11'sd1023, 11'sd1023);
        send_command(qmm_pkg::OP_MIX, 12'd0, -11'sd1024, -11'sd1024, -11'sd1024);
        send_command(qmm_pkg::OP_MIX, 12'd1500, 11'sd100, -11'sd50, 11'sd25);
        send_command(qmm_pkg::OP_YAW, 12'd1500, 11'sd1023, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_DIRECT, 12'd1234, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_RAMP, 12'd0, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_DISARM, 12'd0, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_ESTOP, 12'd0, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_ARM, 12'd0, 11'sd0, 11'sd0, 11'sd0);
        send_command(qmm_pkg::OP_ESTOP, 12'd0, 11'sd0, 11'sd0, 11'sd0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: configure(11'd1000, 11'd1050, 11'd1200, 11'd2);
                1: configure(11'd0, 11'd0, 11'd2000, 11'd255);
                2: configure(11'd2000, 11'd1950, 11'd0, 11'd1);
                // floor beyond the esc range and a zero step
                3: configure(11'd2047, 11'd2047, 11'd2047, 11'h700);
                4, 5: configure(11'($urandom_range(1200, 900)), 11'($urandom_range(1300, 950)),
                                11'($urandom_range(1900, 1000)),
                                {3'($urandom), 8'($urandom_range(255, 1))});
                default: configure(11'($urandom), 11'($urandom), 11'($urandom),
                                   11'($urandom));
            endcase
            mode = idle_mode_t'(ph % 4);
            tx_idle_pct = (mode == IDLE_TX) ? 74 : (mode == IDLE_BOTH) ? 8 : 0;
            rx_stall_pct = (mode == IDLE_RX) ? 74 : (mode == IDLE_BOTH) ? 8 : 0;
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                case ($urandom_range(9))
                    0, 1: begin
                        k = $urandom_range(40, 1);
                        send_random(qmm_pkg::OP_ARM);
                        for (int j = 0; j < k; j++) begin
                            send_random(($urandom_range(3) == 0) ? qmm_pkg::OP_MIX
                                                                 : qmm_pkg::OP_RAMP);
                        end
                        count += k + 1;
                    end
                    2, 3, 4: begin
                        k = $urandom_range(6, 1);
                        repeat (k) send_random(qmm_pkg::OP_MIX);
                        count += k;
                    end
                    5: begin
                        send_random(qmm_pkg::OP_YAW);
                        count++;
                    end
                    6: begin
                        send_random(qmm_pkg::OP_DIRECT);
                        count++;
                    end
                    7: begin
                        send_random($urandom_range(1) ? qmm_pkg::OP_DISARM
                                                      : qmm_pkg::OP_ESTOP);
                        count++;
                    end
                    8: begin
                        send_random(3'($urandom_range(7)));
                        count++;
                    end
                    default: begin
                        send_random(qmm_pkg::OP_RAMP);
                        count++;
                    end
                endcase
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
